// ----- rtl/baro_pressure_temp_compensation_unit_defines.svh -----
// assertion macros used by the compensation unit top level
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_UNIT_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_UNIT_DEFINES_SVH

// plain property, checked outside reset
`define BARO_PTC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define BARO_PTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    `BARO_PTC_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication
`define BARO_PTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    `BARO_PTC_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ----- rtl/baro_ptc_pkg.sv -----
// shared types and constants of the pressure and temperature compensation unit
`timescale 1ns / 1ps

package baro_ptc_pkg;

    localparam int unsigned CoefW    = 16;
    localparam int unsigned RawW     = 24;
    localparam int unsigned TempW    = 15;
    localparam int unsigned PresW    = 17;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned NumStages = 10;

    // temperature reference and very-low offset (temp + 1500 = (temp - 2000) + 3500)
    localparam int TempRef     = 2000;
    localparam int TempVlowOfs = 3500;

    // output saturation limits
    localparam int TempMin = -4000;
    localparam int TempMax = 8500;
    localparam int PresMin = 1000;
    localparam int PresMax = 120000;

    // calibration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_C1 = 3'd0,
        CFG_C2 = 3'd1,
        CFG_C3 = 3'd2,
        CFG_C4 = 3'd3,
        CFG_C5 = 3'd4,
        CFG_C6 = 3'd5
    } t_cfg_idx;

    // calibration words as seen by the datapath
    typedef struct packed {
        logic [CoefW-1:0] c1;
        logic [CoefW-1:0] c2;
        logic [CoefW-1:0] c3;
        logic [CoefW-1:0] c4;
        logic [CoefW-1:0] c5;
        logic [CoefW-1:0] c6;
    } t_coefs;

endpackage

// ----- rtl/baro_ptc_cfg_regs.sv -----
// calibration word register file with index decode
`timescale 1ns / 1ps

module baro_ptc_cfg_regs
    import baro_ptc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CoefW-1:0]   i_cfg_data,
    output t_coefs             o_coefs
);

    t_coefs r_coefs;
    t_coefs n_coefs;

    // index decode, unknown indexes leave everything alone
    always_comb begin
        n_coefs = r_coefs;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_C1:  n_coefs.c1 = i_cfg_data;
                CFG_C2:  n_coefs.c2 = i_cfg_data;
                CFG_C3:  n_coefs.c3 = i_cfg_data;
                CFG_C4:  n_coefs.c4 = i_cfg_data;
                CFG_C5:  n_coefs.c5 = i_cfg_data;
                CFG_C6:  n_coefs.c6 = i_cfg_data;
                default: n_coefs = r_coefs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else begin
            r_coefs <= n_coefs;
        end
    end

    assign o_coefs = r_coefs;

endmodule

// ----- rtl/baro_pressure_temp_compensation_unit.sv -----
// top level: ten-stage pipeline for second-order pressure and temperature compensation
`timescale 1ns / 1ps
`include "baro_pressure_temp_compensation_unit_defines.svh"

// Takes one raw pressure and one raw temperature conversion per word and returns the
// compensated temperature (0.01 C, saturated to -4000..8500) and pressure (0.01 mbar,
// saturated to 1000..120000). Six calibration words are written through the cfg port
// (index 0..5, others ignored); the user writes them only while the unit is idle, which
// the block does not enforce. The datapath is a ten-stage pipeline with a valid bit per
// stage: a new word can enter every cycle while o_in_ready is high. Each stage moves on
// when the stage after it is free, so words keep flowing into empty stages while a
// finished result waits at the output. The pressure product (24 x 40 bits) is split into
// two partial products over two stages.
module baro_pressure_temp_compensation_unit
    import baro_ptc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // calibration write port
    input  logic                    i_cfg_we,
    input  logic [CfgIdxW-1:0]      i_cfg_idx,
    input  logic [CoefW-1:0]        i_cfg_data,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [RawW-1:0]         i_raw_pressure,
    input  logic [RawW-1:0]         i_raw_temperature,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [TempW-1:0] o_temperature_centideg,
    output logic [PresW-1:0]        o_pressure_centimbar
);

    t_coefs w_coefs;

    baro_ptc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coefs    (w_coefs)
    );

    // stage control
    logic [NumStages-1:0] r_vld;
    logic [NumStages-1:0] w_en;

    always_comb begin
        w_en[NumStages-1] = !r_vld[NumStages-1] || i_out_ready;
        for (int k = NumStages - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NumStages; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NumStages-1];

    // stage registers
    logic [RawW-1:0]     r_s1_d1, r_s2_d1, r_s3_d1, r_s4_d1, r_s5_d1, r_s6_d1;
    logic signed [24:0]  r_s1_dt;
    logic signed [41:0]  r_s2_p6, r_s2_p4, r_s2_p3;
    logic signed [49:0]  r_s2_pdd;
    logic signed [17:0]  r_s3_a;
    logic signed [18:0]  r_s3_b;
    logic signed [19:0]  r_s3_temp1, r_s4_temp1, r_s5_temp;
    logic [17:0]         r_s3_t2, r_s4_t2;
    logic                r_s3_low, r_s4_low, r_s3_vlow, r_s4_vlow;
    logic signed [39:0]  r_s3_off, r_s4_off, r_s5_off, r_s6_off, r_s7_off, r_s8_off;
    logic signed [39:0]  r_s3_sens, r_s4_sens, r_s5_sens, r_s6_sens;
    logic [34:0]         r_s4_a2;
    logic [35:0]         r_s4_b2;
    logic [39:0]         r_s5_off2, r_s5_sens2;
    logic signed [TempW-1:0] r_s6_temp, r_s7_temp, r_s8_temp, r_s9_temp, r_s10_temp;
    logic [43:0]         r_s7_pl;
    logic signed [44:0]  r_s7_ph;
    logic signed [43:0]  r_s8_q;
    logic signed [44:0]  r_s9_r;
    logic [PresW-1:0]    r_s10_pres;

    // next values
    logic signed [24:0]  n_dt;
    logic signed [41:0]  n_p6, n_p4, n_p3;
    logic signed [49:0]  n_pdd;
    logic signed [41:0]  w_a_full, w_off_sh, w_sens_sh;
    logic signed [49:0]  w_t2_sh;
    logic signed [17:0]  n_a;
    logic signed [18:0]  n_b;
    logic signed [19:0]  n_temp1;
    logic [17:0]         n_t2;
    logic signed [39:0]  n_off, n_sens;
    logic signed [35:0]  n_a2;
    logic signed [37:0]  n_b2;
    logic [37:0]         w_a5;
    logic [38:0]         w_b7;
    logic [39:0]         w_b11;
    logic [39:0]         n_off2, n_sens2;
    logic signed [19:0]  n_temp;
    logic signed [39:0]  n_off_f, n_sens_f;
    logic signed [TempW-1:0] n_temp_sat;
    logic [43:0]         n_pl;
    logic signed [44:0]  n_ph;
    logic signed [65:0]  w_sum, w_q_full;
    logic signed [43:0]  n_q;
    logic signed [44:0]  n_r;
    logic signed [44:0]  w_p;
    logic [PresW-1:0]    n_pres;

    // stage 1: temperature difference to reference
    assign n_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, w_coefs.c5, 8'b0});

    // stage 2: the four products on dT
    assign n_p6  = r_s1_dt * $signed({1'b0, w_coefs.c6});
    assign n_p4  = r_s1_dt * $signed({1'b0, w_coefs.c4});
    assign n_p3  = r_s1_dt * $signed({1'b0, w_coefs.c3});
    assign n_pdd = r_s1_dt * r_s1_dt;

    // stage 3: first-order temperature, offset and sensitivity
    always_comb begin
        w_a_full  = r_s2_p6 >>> 23;
        w_off_sh  = r_s2_p4 >>> 7;
        w_sens_sh = r_s2_p3 >>> 8;
        w_t2_sh   = r_s2_pdd >>> 31;
        n_a       = w_a_full[17:0];
        n_b       = {n_a[17], n_a} + 19'(TempVlowOfs);
        n_temp1   = {{2{n_a[17]}}, n_a} + 20'(TempRef);
        n_t2      = w_t2_sh[17:0];
        n_off     = $signed({8'b0, w_coefs.c2, 16'b0}) + w_off_sh[39:0];
        n_sens    = $signed({9'b0, w_coefs.c1, 15'b0}) + w_sens_sh[39:0];
    end

    // stage 4: squares of the distances to both thresholds
    assign n_a2 = r_s3_a * r_s3_a;
    assign n_b2 = r_s3_b * r_s3_b;

    // stage 5: second-order corrections and corrected temperature
    always_comb begin
        w_a5  = {3'b0, r_s4_a2} + {1'b0, r_s4_a2, 2'b0};
        w_b7  = {r_s4_b2, 3'b0} - {3'b0, r_s4_b2};
        w_b11 = {1'b0, r_s4_b2, 3'b0} + {3'b0, r_s4_b2, 1'b0} + {4'b0, r_s4_b2};
        n_off2  = '0;
        n_sens2 = '0;
        n_temp  = r_s4_temp1;
        if (r_s4_low) begin
            n_off2  = {3'b0, w_a5[37:1]} + (r_s4_vlow ? {1'b0, w_b7} : 40'd0);
            n_sens2 = {4'b0, w_a5[37:2]} + (r_s4_vlow ? {1'b0, w_b11[39:1]} : 40'd0);
            n_temp  = r_s4_temp1 - $signed({2'b0, r_s4_t2});
        end
    end

    // stage 6: apply corrections, saturate temperature
    always_comb begin
        n_off_f  = r_s5_off - $signed(r_s5_off2);
        n_sens_f = r_s5_sens - $signed(r_s5_sens2);
        if (r_s5_temp < TempMin) begin
            n_temp_sat = TempW'(TempMin);
        end else if (r_s5_temp > TempMax) begin
            n_temp_sat = TempW'(TempMax);
        end else begin
            n_temp_sat = r_s5_temp[TempW-1:0];
        end
    end

    // stage 7: raw pressure times sensitivity, split in two partial products
    assign n_pl = r_s6_d1 * r_s6_sens[19:0];
    assign n_ph = $signed({1'b0, r_s6_d1}) * $signed(r_s6_sens[39:20]);

    // stage 8: recombine and scale
    always_comb begin
        w_sum    = (66'(r_s7_ph) <<< 20) + $signed({22'b0, r_s7_pl});
        w_q_full = w_sum >>> 21;
        n_q      = w_q_full[43:0];
    end

    // stage 9: remove offset
    assign n_r = 45'(r_s8_q) - 45'(r_s8_off);

    // stage 10: scale and saturate pressure
    always_comb begin
        w_p = r_s9_r >>> 15;
        if (w_p < PresMin) begin
            n_pres = PresW'(PresMin);
        end else if (w_p > PresMax) begin
            n_pres = PresW'(PresMax);
        end else begin
            n_pres = w_p[PresW-1:0];
        end
    end

    // payload registers, each stage loads when it may move
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_d1 <= i_raw_pressure;
            r_s1_dt <= n_dt;
        end
        if (w_en[1]) begin
            r_s2_d1  <= r_s1_d1;
            r_s2_p6  <= n_p6;
            r_s2_p4  <= n_p4;
            r_s2_p3  <= n_p3;
            r_s2_pdd <= n_pdd;
        end
        if (w_en[2]) begin
            r_s3_d1    <= r_s2_d1;
            r_s3_a     <= n_a;
            r_s3_b     <= n_b;
            r_s3_temp1 <= n_temp1;
            r_s3_t2    <= n_t2;
            r_s3_low   <= n_a[17];
            r_s3_vlow  <= n_b[18];
            r_s3_off   <= n_off;
            r_s3_sens  <= n_sens;
        end
        if (w_en[3]) begin
            r_s4_d1    <= r_s3_d1;
            r_s4_a2    <= n_a2[34:0];
            r_s4_b2    <= n_b2[35:0];
            r_s4_temp1 <= r_s3_temp1;
            r_s4_t2    <= r_s3_t2;
            r_s4_low   <= r_s3_low;
            r_s4_vlow  <= r_s3_vlow;
            r_s4_off   <= r_s3_off;
            r_s4_sens  <= r_s3_sens;
        end
        if (w_en[4]) begin
            r_s5_d1    <= r_s4_d1;
            r_s5_temp  <= n_temp;
            r_s5_off   <= r_s4_off;
            r_s5_sens  <= r_s4_sens;
            r_s5_off2  <= n_off2;
            r_s5_sens2 <= n_sens2;
        end
        if (w_en[5]) begin
            r_s6_d1   <= r_s5_d1;
            r_s6_temp <= n_temp_sat;
            r_s6_off  <= n_off_f;
            r_s6_sens <= n_sens_f;
        end
        if (w_en[6]) begin
            r_s7_temp <= r_s6_temp;
            r_s7_off  <= r_s6_off;
            r_s7_pl   <= n_pl;
            r_s7_ph   <= n_ph;
        end
        if (w_en[7]) begin
            r_s8_temp <= r_s7_temp;
            r_s8_off  <= r_s7_off;
            r_s8_q    <= n_q;
        end
        if (w_en[8]) begin
            r_s9_temp <= r_s8_temp;
            r_s9_r    <= n_r;
        end
        if (w_en[9]) begin
            r_s10_temp <= r_s9_temp;
            r_s10_pres <= n_pres;
        end
    end

    assign o_temperature_centideg = r_s10_temp;
    assign o_pressure_centimbar   = r_s10_pres;

    // checks
    `BARO_PTC_ASSERT_NEXT(a_in_lands, i_clk, i_rst_n, i_in_valid && o_in_ready, r_vld[0],
        "accepted word missing from first stage")
    `BARO_PTC_ASSERT_IMP(a_temp_range, i_clk, i_rst_n, o_out_valid,
        (o_temperature_centideg >= TempMin) && (o_temperature_centideg <= TempMax),
        "temperature outside rated range")
    `BARO_PTC_ASSERT_IMP(a_pres_range, i_clk, i_rst_n, o_out_valid,
        (o_pressure_centimbar >= PresMin) && (o_pressure_centimbar <= PresMax),
        "pressure outside rated range")

endmodule

// ----- dv/baro_pressure_temp_compensation_unit_tb.sv -----
// self-checking testbench for the pressure and temperature compensation unit
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_unit_tb;
    import baro_ptc_pkg::*;

    // writes to these indexes must leave the calibration untouched
    localparam logic [CfgIdxW-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_UNUSED_HI = 3'd7;

    localparam longint VlowTemp     = TempRef - TempVlowOfs;
    localparam logic [RawW-1:0] RawMax = {RawW{1'b1}};
    localparam int WatchdogLimit    = 3000;
    localparam int PhaseWords       = 105;
    localparam int NumPhases        = 8;

    typedef struct {
        logic signed [TempW-1:0] temperature;
        logic [PresW-1:0]        pressure;
    } t_reading;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CfgIdxW-1:0]      i_cfg_idx;
    logic [CoefW-1:0]        i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [RawW-1:0]         i_raw_pressure;
    logic [RawW-1:0]         i_raw_temperature;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b1;
    logic signed [TempW-1:0] o_temperature_centideg;
    logic [PresW-1:0]        o_pressure_centimbar;

    // calibration as the unit should hold it, and readings still owed
    t_coefs      cal_now;
    t_reading    pending_readings[$];
    int          mismatches   = 0;
    int unsigned in_gap       = 1;
    int unsigned out_stall    = 0;
    int          quiet_cycles = 0;
    bit          no_idle      = 1'b0;

    baro_pressure_temp_compensation_unit dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_idx              (i_cfg_idx),
        .i_cfg_data             (i_cfg_data),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_raw_pressure         (i_raw_pressure),
        .i_raw_temperature      (i_raw_temperature),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_temperature_centideg (o_temperature_centideg),
        .o_pressure_centimbar   (o_pressure_centimbar)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // second-order compensation of one raw pair with the current calibration
    function automatic t_reading compensate_reading(input logic [RawW-1:0] raw_p,
                                                    input logic [RawW-1:0] raw_t);
        t_reading res;
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, temp, off, sens, t2, off2, sens2, a, b, p;
        d1 = longint'({40'd0, raw_p});
        d2 = longint'({40'd0, raw_t});
        c1 = longint'({48'd0, cal_now.c1});
        c2 = longint'({48'd0, cal_now.c2});
        c3 = longint'({48'd0, cal_now.c3});
        c4 = longint'({48'd0, cal_now.c4});
        c5 = longint'({48'd0, cal_now.c5});
        c6 = longint'({48'd0, cal_now.c6});
        // first order
        dt   = d2 - c5 * 256;
        temp = TempRef + ((dt * c6) >>> 23);
        off  = c2 * 65536 + ((c4 * dt) >>> 7);
        sens = c1 * 32768 + ((c3 * dt) >>> 8);
        // low and very-low temperature corrections, judged on the first-order value
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        if (temp < TempRef) begin
            a     = temp - TempRef;
            t2    = (dt * dt) >>> 31;
            off2  = (5 * a * a) >>> 1;
            sens2 = (5 * a * a) >>> 2;
            if (temp < VlowTemp) begin
                b     = temp - VlowTemp;
                off2  = off2 + 7 * b * b;
                sens2 = sens2 + ((11 * b * b) >>> 1);
            end
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
        p    = (((d1 * sens) >>> 21) - off) >>> 15;
        // saturate to the rated range
        if (temp < TempMin) temp = TempMin;
        if (temp > TempMax) temp = TempMax;
        if (p < PresMin) p = PresMin;
        if (p > PresMax) p = PresMax;
        res.temperature = temp[TempW-1:0];
        res.pressure    = p[PresW-1:0];
        return res;
    endfunction

    // raw temperature that puts the first-order temperature just at the target
    function automatic logic [RawW-1:0] raw_temp_for(input int centideg);
        longint num, dt, d2, c6;
        c6 = longint'({48'd0, cal_now.c6});
        if (c6 == 0)
            return RawW'($urandom);
        num = longint'(centideg - TempRef) * 64'sd8388608;
        if (num >= 0)
            dt = (num + c6 - 1) / c6;
        else
            dt = num / c6;
        d2 = longint'({48'd0, cal_now.c5}) * 256 + dt;
        if (d2 < 0) d2 = 0;
        if (d2 > longint'(RawMax)) d2 = longint'(RawMax);
        return d2[RawW-1:0];
    endfunction

    // one calibration register write
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_C1:  cal_now.c1 = value;
            CFG_C2:  cal_now.c2 = value;
            CFG_C3:  cal_now.c3 = value;
            CFG_C4:  cal_now.c4 = value;
            CFG_C5:  cal_now.c5 = value;
            CFG_C6:  cal_now.c6 = value;
            default: ;
        endcase
    endtask

    task automatic load_calibration(input t_coefs cal);
        write_reg(CFG_C1, cal.c1);
        write_reg(CFG_C2, cal.c2);
        write_reg(CFG_C3, cal.c3);
        write_reg(CFG_C4, cal.c4);
        write_reg(CFG_C5, cal.c5);
        write_reg(CFG_C6, cal.c6);
    endtask

    // send one raw pair; valid stays up on return when the next word follows at once
    task automatic send_word(input logic [RawW-1:0] raw_p, input logic [RawW-1:0] raw_t);
        repeat (in_gap) @(posedge i_clk);
        i_in_valid        <= 1'b1;
        i_raw_pressure    <= raw_p;
        i_raw_temperature <= raw_t;
        do @(posedge i_clk); while (!o_in_ready);
        pending_readings.push_back(compensate_reading(raw_p, raw_t));
        in_gap = no_idle ? 0 : $urandom_range(0, 8);
        if (in_gap > 0)
            i_in_valid <= 1'b0;
    endtask

    // drop valid in the step of the last acceptance, then wait for every reading
    task automatic settle();
        if (in_gap == 0) begin
            i_in_valid <= 1'b0;
            in_gap = 1;
        end
        while (pending_readings.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_unset_calibration();
        send_word('0, '0);
        send_word(RawMax, RawMax);
        send_word(RawW'($urandom), RawW'($urandom));
        settle();
    endtask

    task automatic test_register_index();
        t_coefs nominal;
        nominal = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                    c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};
        load_calibration(nominal);
        write_reg(CFG_UNUSED_LO, 16'hFFFF);
        write_reg(CFG_UNUSED_HI, 16'hFFFF);
        send_word(24'd9085466, 24'd8569150);
        send_word(24'd9085466, raw_temp_for(-2500));
        settle();
    endtask

    task automatic test_field_extremes();
        logic [RawW-1:0] ref_raw;
        ref_raw = {cal_now.c5, 8'd0};
        send_word('0, '0);
        send_word(RawMax, RawMax);
        send_word('0, RawMax);
        send_word(RawMax, '0);
        send_word(RawMax, ref_raw);
        send_word('0, ref_raw);
        settle();
        // every calibration word at its top
        load_calibration('{default: 16'hFFFF});
        send_word('0, '0);
        send_word(RawMax, RawMax);
        send_word(RawMax, '0);
        send_word('0, RawMax);
        settle();
    endtask

    // either side of the 20.00 C and -15.00 C thresholds
    task automatic test_temp_thresholds();
        load_calibration('{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                           c4: 16'd23282, c5: 16'd33464, c6: 16'd28312});
        send_word(24'd9085466, raw_temp_for(2001));
        send_word(24'd9085466, raw_temp_for(2000));
        send_word(24'd9085466, raw_temp_for(1999));
        send_word(24'd8500000, raw_temp_for(-1499));
        send_word(24'd8500000, raw_temp_for(-1500));
        send_word(24'd8500000, raw_temp_for(-1501));
        settle();
    endtask

    task automatic test_random_readings();
        t_coefs          cal;
        logic [RawW-1:0] raw_p;
        logic [RawW-1:0] raw_t;
        int              pick;
        for (int phase = 0; phase < NumPhases; phase++) begin
            // calibration: nominal, jittered about nominal, or fully random
            cal = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                    c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};
            if (phase % 2 == 1) begin
                cal.c1 = CoefW'($urandom);
                cal.c2 = CoefW'($urandom);
                cal.c3 = CoefW'($urandom);
                cal.c4 = CoefW'($urandom);
                cal.c5 = CoefW'($urandom);
                cal.c6 = CoefW'($urandom);
            end else if (phase > 0) begin
                cal.c1 = cal.c1 - 16'd8000 + 16'($urandom_range(0, 16000));
                cal.c2 = cal.c2 - 16'd8000 + 16'($urandom_range(0, 16000));
                cal.c3 = cal.c3 - 16'd8000 + 16'($urandom_range(0, 16000));
                cal.c4 = cal.c4 - 16'd8000 + 16'($urandom_range(0, 16000));
                cal.c5 = cal.c5 - 16'd4000 + 16'($urandom_range(0, 8000));
                cal.c6 = cal.c6 - 16'd8000 + 16'($urandom_range(0, 16000));
            end
            load_calibration(cal);
            no_idle = (phase == 3 || phase == 6);
            for (int n = 0; n < PhaseWords; n++) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    // temperature aimed across the whole rated range and a bit beyond
                    raw_t = raw_temp_for(int'($urandom_range(0, 13500)) - 4800);
                    if (pick < 4)
                        raw_p = 24'd5000000 + 24'($urandom_range(0, 7000000));
                    else
                        raw_p = RawW'($urandom);
                end else begin
                    raw_p = RawW'($urandom);
                    raw_t = RawW'($urandom);
                end
                send_word(raw_p, raw_t);
                // hold off mid-phase until the pipeline has emptied
                if (n == PhaseWords / 2 && phase % 3 == 0)
                    settle();
            end
            settle();
        end
        no_idle = 1'b0;
    endtask

    // result checker and output-side stalls
    always @(posedge i_clk) begin : result_check
        t_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_readings.size() == 0) begin
                $error("output word with no reading expected");
                mismatches++;
            end else begin
                want = pending_readings.pop_front();
                if (o_temperature_centideg !== want.temperature) begin
                    $error("temperature_centideg: expected %0d, got %0d",
                           want.temperature, o_temperature_centideg);
                    mismatches++;
                end
                if (o_pressure_centimbar !== want.pressure) begin
                    $error("pressure_centimbar: expected %0d, got %0d",
                           want.pressure, o_pressure_centimbar);
                    mismatches++;
                end
            end
            out_stall = no_idle ? 0 : $urandom_range(0, 8);
            if (out_stall > 0)
                i_out_ready <= 1'b0;
        end else if (!i_out_ready) begin
            out_stall--;
            if (out_stall == 0)
                i_out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("baro_pressure_temp_compensation_unit_tb NOT OK");
            $finish;
        end
    end

    initial begin
        cal_now           = '0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= '0;
        i_cfg_data        <= '0;
        i_in_valid        <= 1'b0;
        i_raw_pressure    <= '0;
        i_raw_temperature <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_unset_calibration();
        test_register_index();
        test_field_extremes();
        test_temp_thresholds();
        test_random_readings();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("baro_pressure_temp_compensation_unit_tb OK");
        else
            $display("baro_pressure_temp_compensation_unit_tb NOT OK");
        $finish;
    end

endmodule
